[hw/rtl/clex_pkg.sv]
// Shared types, constants and byte classes of the C-like token lexer.
package clex_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 24;
	localparam int FIFO_DEPTH      = 4;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	typedef enum logic [3:0] {
		M_IDLE, M_NUMBER, M_ZERO, M_IDENT, M_SLASH, M_LINE_CMT, M_BLOCK,
		M_BLOCK_STAR, M_LT, M_GT, M_EQ, M_BANG, M_AMP, M_PIPE, M_ERROR
	} lex_mode_t;

	typedef enum logic [4:0] {
		K_END = 5'd0, K_NUMBER = 5'd1, K_IDENT = 5'd2, K_PLUS = 5'd3,
		K_MINUS = 5'd4, K_STAR = 5'd5, K_SLASH = 5'd6, K_PERCENT = 5'd7,
		K_LT = 5'd8, K_LE = 5'd9, K_GT = 5'd10, K_GE = 5'd11,
		K_ASSIGN = 5'd12, K_EQ = 5'd13, K_NOT = 5'd14, K_NE = 5'd15,
		K_AND = 5'd16, K_OR = 5'd17, K_SEMI = 5'd18, K_COMMA = 5'd19,
		K_LPAREN = 5'd20, K_RPAREN = 5'd21, K_LBRACE = 5'd22,
		K_RBRACE = 5'd23, K_INVALID = 5'd24, K_ZERO_ERR = 5'd25,
		K_CMT_ERR = 5'd26
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [23:0] offset;
		logic [15:0] len;
		logic        last;
	} tok_t;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == CH_US);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// mode entered by a byte seen with nothing held; idle when it holds nothing
	function automatic lex_mode_t hold_mode(input logic [7:0] c);
		hold_mode = M_IDLE;
		case (c) inside
			8'h30:          hold_mode = M_ZERO;
			[8'h31:8'h39]:  hold_mode = M_NUMBER;
			[8'h61:8'h7A],
			[8'h41:8'h5A],
			CH_US:          hold_mode = M_IDENT;
			CH_SLASH:       hold_mode = M_SLASH;
			8'h3C:          hold_mode = M_LT;
			8'h3E:          hold_mode = M_GT;
			CH_EQ:          hold_mode = M_EQ;
			8'h21:          hold_mode = M_BANG;
			CH_AMP:         hold_mode = M_AMP;
			CH_PIPE:        hold_mode = M_PIPE;
			default:        hold_mode = M_IDLE;
		endcase
	endfunction

	function automatic tok_kind_t single_kind(input logic [7:0] c);
		case (c)
			8'h2B:   single_kind = K_PLUS;
			8'h2D:   single_kind = K_MINUS;
			CH_STAR: single_kind = K_STAR;
			8'h25:   single_kind = K_PERCENT;
			8'h3B:   single_kind = K_SEMI;
			8'h2C:   single_kind = K_COMMA;
			8'h28:   single_kind = K_LPAREN;
			8'h29:   single_kind = K_RPAREN;
			8'h7B:   single_kind = K_LBRACE;
			8'h7D:   single_kind = K_RBRACE;
			default: single_kind = K_INVALID;
		endcase
	endfunction

	function automatic tok_kind_t flush_kind(input lex_mode_t m);
		case (m)
			M_NUMBER, M_ZERO:     flush_kind = K_NUMBER;
			M_IDENT:              flush_kind = K_IDENT;
			M_SLASH:              flush_kind = K_SLASH;
			M_LT:                 flush_kind = K_LT;
			M_GT:                 flush_kind = K_GT;
			M_EQ:                 flush_kind = K_ASSIGN;
			M_BANG:               flush_kind = K_NOT;
			M_AMP, M_PIPE:        flush_kind = K_INVALID;
			M_BLOCK, M_BLOCK_STAR: flush_kind = K_CMT_ERR;
			default:              flush_kind = K_END;
		endcase
	endfunction

	function automatic tok_kind_t pair_kind(input lex_mode_t m);
		case (m)
			M_LT:    pair_kind = K_LE;
			M_GT:    pair_kind = K_GE;
			M_EQ:    pair_kind = K_EQ;
			M_BANG:  pair_kind = K_NE;
			M_AMP:   pair_kind = K_AND;
			M_PIPE:  pair_kind = K_OR;
			default: pair_kind = K_INVALID;
		endcase
	endfunction

	function automatic logic [7:0] pair_char(input lex_mode_t m);
		case (m)
			M_AMP:   pair_char = CH_AMP;
			M_PIPE:  pair_char = CH_PIPE;
			default: pair_char = CH_EQ;
		endcase
	endfunction

endpackage

[hw/rtl/clex_src_if.sv]
// Source byte channel of the lexer.
interface clex_src_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] source_byte;

	modport source (output valid, output kind, output source_byte, input ready);
	modport sink (input valid, input kind, input source_byte, output ready);
endinterface

[hw/rtl/clex_tok_if.sv]
// Token result channel of the lexer.
interface clex_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] first_line;
	logic [15:0] first_column;
	logic [23:0] start_offset;
	logic [15:0] token_length;
	logic        run_last;

	modport source (output valid, output token_kind, output first_line,
		output first_column, output start_offset, output token_length,
		output run_last, input ready);
	modport sink (input valid, input token_kind, input first_line,
		input first_column, input start_offset, input token_length,
		input run_last, output ready);
endinterface

[hw/rtl/c_like_token_lexer.sv]
// Streaming lexer: source bytes in, position-tagged tokens out.
//
// src carries one source byte per item (kind 0) or an end-of-source marker
// (kind 1). tokens carries the tokens, each with kind, start line, start
// column, start offset and length; run_last marks the last token caused by
// one src item. An item causes zero, one or two tokens.
// A token caused by an item is written to the result queue when the item is
// accepted and is valid on tokens from the cycle after, at the earliest.
// Throughput: one src item per cycle while at least two queue entries are
// free and items cause at most one token each; the single tokens port moves
// one token per cycle, so items that cause two tokens fill the queue faster
// than it drains. The lexer state and counters update in the same cycle an
// item is accepted, and the tokens go into a four-entry result queue.
// Reset: lexer idle, line and column at one, offset zero, queue empty.
// Stall: the queue holds tokens while tokens.ready is low; src.ready drops
// when fewer than two queue entries are free and rises as tokens drain.
// After end of source, the line, column and offset counters are back at their reset values.
module c_like_token_lexer #(
	parameter int LINE_BITS   = clex_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = clex_pkg::COLUMN_BITS_DEF,
	parameter int OFFSET_BITS = clex_pkg::OFFSET_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	clex_src_if.sink  src,
	clex_tok_if.source tokens
);

	localparam int LW    = (LINE_BITS > 16) ? LINE_BITS : 16;
	localparam int CW    = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
	localparam int OW    = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
	localparam int DEPTH = clex_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [LW-1:0] w;
		w = LW'(v);
		sat_line = (w > LW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [15:0] sat_col(input logic [COLUMN_BITS-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		sat_col = (w > CW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [23:0] sat_off(input logic [OFFSET_BITS-1:0] v);
		logic [OW-1:0] w;
		w = OW'(v);
		sat_off = (w > OW'(24'hFFFFFF)) ? 24'hFFFFFF : w[23:0];
	endfunction

	clex_pkg::lex_mode_t    mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d, tline_q, tline_d;
	logic [COLUMN_BITS-1:0] col_q, col_d, tcol_q, tcol_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, toff_q, toff_d;
	logic [15:0]            tlen_q, tlen_d, tlen_inc, hlen;

	clex_pkg::tok_t         fifo_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [CNT_W-1:0]       count_q;

	logic                   acc, pop;
	logic [7:0]             c;
	logic                   emit_h, disp, d_space, d_emit, is_pair;
	clex_pkg::lex_mode_t    d_mode;
	clex_pkg::tok_kind_t    hkind, fkind;
	clex_pkg::tok_t         held, cur, eos_tok, res0, res1;
	logic [1:0]             n_res;

	assign c        = src.source_byte;
	assign acc      = src.valid && src.ready;
	assign pop      = tokens.valid && tokens.ready;
	assign src.ready = (count_q <= CNT_W'(DEPTH - 2));
	assign tlen_inc = (tlen_q == 16'hFFFF) ? tlen_q : tlen_q + 16'd1;
	assign d_mode   = clex_pkg::hold_mode(c);
	assign d_space  = clex_pkg::is_space(c);
	assign d_emit   = !d_space && (d_mode == clex_pkg::M_IDLE);
	assign fkind    = clex_pkg::flush_kind(mode_q);
	assign is_pair  = (c == clex_pkg::pair_char(mode_q));
	assign wr_ptr1  = wr_ptr_q + PTR_W'(1);

	always_comb begin
		held = '{kind: clex_pkg::K_END, line: sat_line(tline_q), column: sat_col(tcol_q),
			offset: sat_off(toff_q), len: tlen_q, last: 1'b0};
		cur = '{kind: clex_pkg::single_kind(c), line: sat_line(line_q),
			column: sat_col(col_q), offset: sat_off(pos_q), len: 16'd1, last: 1'b0};
		eos_tok = '{kind: clex_pkg::K_END, line: sat_line(line_q),
			column: sat_col(col_q), offset: sat_off(pos_q), len: 16'd0, last: 1'b1};
	end

	always_comb begin
		mode_d  = mode_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		toff_d  = toff_q;
		tlen_d  = tlen_q;
		emit_h  = 1'b0;
		hkind   = clex_pkg::K_END;
		hlen    = tlen_q;
		disp    = 1'b0;
		res0    = cur;
		res1    = cur;
		n_res   = 2'd0;
		line_d  = line_q;
		col_d   = col_q;
		pos_d   = pos_q;
		if (src.kind) begin
			hkind = fkind;
			if (fkind != clex_pkg::K_END) begin
				res0      = held;
				res0.kind = hkind;
				res0.len  = hlen;
				res1      = eos_tok;
				n_res     = 2'd2;
			end else begin
				res0  = eos_tok;
				n_res = 2'd1;
			end
			mode_d  = clex_pkg::M_IDLE;
			line_d  = LINE_BITS'(1);
			col_d   = COLUMN_BITS'(1);
			pos_d   = '0;
			tline_d = LINE_BITS'(1);
			tcol_d  = COLUMN_BITS'(1);
			toff_d  = '0;
			tlen_d  = 16'd0;
		end else begin
			case (mode_q)
				clex_pkg::M_NUMBER, clex_pkg::M_IDENT: begin
					if (clex_pkg::is_digit(c)
							|| (mode_q == clex_pkg::M_IDENT && clex_pkg::is_alpha(c))) begin
						tlen_d = tlen_inc;
					end else begin
						emit_h = 1'b1;
						hkind  = (mode_q == clex_pkg::M_NUMBER) ? clex_pkg::K_NUMBER
							: clex_pkg::K_IDENT;
						disp   = 1'b1;
					end
				end
				clex_pkg::M_ZERO: begin
					emit_h = 1'b1;
					if (clex_pkg::is_digit(c)) begin
						hkind  = clex_pkg::K_ZERO_ERR;
						hlen   = 16'd2;
						tlen_d = 16'd2;
						mode_d = clex_pkg::M_ERROR;
					end else begin
						hkind = clex_pkg::K_NUMBER;
						disp  = 1'b1;
					end
				end
				clex_pkg::M_SLASH: begin
					if (c == clex_pkg::CH_SLASH) begin
						mode_d = clex_pkg::M_LINE_CMT;
					end else if (c == clex_pkg::CH_STAR) begin
						tlen_d = 16'd2;
						mode_d = clex_pkg::M_BLOCK;
					end else begin
						emit_h = 1'b1;
						hkind  = clex_pkg::K_SLASH;
						disp   = 1'b1;
					end
				end
				clex_pkg::M_LINE_CMT: begin
					if (c == clex_pkg::CH_NL) begin
						mode_d = clex_pkg::M_IDLE;
					end
				end
				clex_pkg::M_BLOCK, clex_pkg::M_BLOCK_STAR: begin
					tlen_d = tlen_inc;
					if (mode_q == clex_pkg::M_BLOCK_STAR && c == clex_pkg::CH_SLASH) begin
						mode_d = clex_pkg::M_IDLE;
					end else if (c == clex_pkg::CH_STAR) begin
						mode_d = clex_pkg::M_BLOCK_STAR;
					end else begin
						mode_d = clex_pkg::M_BLOCK;
					end
				end
				clex_pkg::M_LT, clex_pkg::M_GT, clex_pkg::M_EQ, clex_pkg::M_BANG,
				clex_pkg::M_AMP, clex_pkg::M_PIPE: begin
					emit_h = 1'b1;
					if (is_pair) begin
						hkind  = clex_pkg::pair_kind(mode_q);
						hlen   = 16'd2;
						tlen_d = 16'd2;
						mode_d = clex_pkg::M_IDLE;
					end else begin
						hkind = fkind;
						disp  = 1'b1;
					end
				end
				clex_pkg::M_ERROR: begin
				end
				default: begin
					disp = 1'b1;
				end
			endcase
			if (disp) begin
				mode_d = clex_pkg::M_IDLE;
				if (!d_space && d_mode != clex_pkg::M_IDLE) begin
					mode_d  = d_mode;
					tline_d = line_q;
					tcol_d  = col_q;
					toff_d  = pos_q;
					tlen_d  = 16'd1;
				end
			end
			if (emit_h) begin
				res0      = held;
				res0.kind = hkind;
				res0.len  = hlen;
				n_res     = (disp && d_emit) ? 2'd2 : 2'd1;
			end else if (disp && d_emit) begin
				n_res = 2'd1;
			end
			if (n_res == 2'd2) begin
				res1.last = 1'b1;
			end else begin
				res0.last = 1'b1;
			end
			pos_d = (pos_q == '1) ? pos_q : pos_q + OFFSET_BITS'(1);
			if (c == clex_pkg::CH_NL) begin
				line_d = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
				col_d  = COLUMN_BITS'(1);
			end else begin
				col_d = (col_q == '1) ? col_q : col_q + COLUMN_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= clex_pkg::M_IDLE;
			line_q  <= LINE_BITS'(1);
			col_q   <= COLUMN_BITS'(1);
			pos_q   <= '0;
			tline_q <= LINE_BITS'(1);
			tcol_q  <= COLUMN_BITS'(1);
			toff_q  <= '0;
			tlen_q  <= 16'd0;
		end else if (acc) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			col_q   <= col_d;
			pos_q   <= pos_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			toff_q  <= toff_d;
			tlen_q  <= tlen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
			if (n_res == 2'd2) begin
				fifo_q[wr_ptr1] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (acc ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign tokens.valid        = (count_q != '0);
	assign tokens.token_kind   = fifo_q[rd_ptr_q].kind;
	assign tokens.first_line   = fifo_q[rd_ptr_q].line;
	assign tokens.first_column = fifo_q[rd_ptr_q].column;
	assign tokens.start_offset = fifo_q[rd_ptr_q].offset;
	assign tokens.token_length = fifo_q[rd_ptr_q].len;
	assign tokens.run_last     = fifo_q[rd_ptr_q].last;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue count out of range");

	a_partner_queued: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && !tokens.run_last |-> count_q >= CNT_W'(2))
		else $error("non-last token without its partner in the queue");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_kind == clex_pkg::K_END |-> tokens.run_last)
		else $error("end token not marked last");

	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && src.kind |=> mode_q == clex_pkg::M_IDLE && line_q == LINE_BITS'(1)
			&& pos_q == '0)
		else $error("state not back at reset after end of source");
`endif

endmodule
